### design/tprq_pkg.sv
// ----------------------------------------------------------------------------
// tprq_pkg
// Types and constants shared by the timestamp paced release queue.
// ----------------------------------------------------------------------------
package tprq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int CMD_W   = 2;
  localparam int TAG_W   = 16;
  localparam int TS_W    = 32;
  localparam int NOW_W   = 48;
  localparam int RATE_W  = 20;
  localparam int ORIG_W  = NOW_W + 1;
  localparam int DIFF_W  = 64;
  localparam int MSC_W   = 10;
  localparam int PROD_W  = TS_W + MSC_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam int S_TDATA_W = TAG_W + TS_W + NOW_W;
  localparam int M_TDATA_W = TAG_W + TS_W;
  localparam int M_TUSER_W = 2;

  localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(8000);
  localparam logic [MSC_W-1:0]  MS_PER_S     = MSC_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_GET   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  ts;
  } entry_t;

endpackage

### design/timestamp_paced_release_queue.sv
// ----------------------------------------------------------------------------
// timestamp_paced_release_queue
// Packet tag fifo that releases the head once its media timestamp, converted
// to milliseconds, has been reached against a time origin set by the first get.
//
//   channel   dir   handshake          contents
//   s_*       in    tvalid/tready      tuser: cmd; tdata: tag, timestamp, now_ms
//   m_*       out   tvalid/tready      tuser: released, dropped; tdata: tag, ts
//   cfg_*     in    cfg_wen            cfg_wdata: media_clock_rate
//
// push, flush, no-op and empty-queue get words pass through the exec and done
// states to the output register.
// a get on a non-empty queue also passes through the read, multiply, divide and
// decide states; the 42-step restoring divider converts the head timestamp to ms.
// rst is synchronous; it clears pointers, count, origin, rate and state, not the entry memory.
// a new word is accepted while a finished result waits in the output register;
// a second result waits in the done state until that register is taken.
// ----------------------------------------------------------------------------
module timestamp_paced_release_queue
  import tprq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [RATE_W-1:0]     cfg_wdata,    // media_clock_rate
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,      // pkt_tag, pkt_timestamp, now_ms
  input  logic [CMD_W-1:0]      s_tuser,      // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,      // out_tag, out_timestamp
  output logic [M_TUSER_W-1:0]  m_tuser       // released, dropped
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  logic [RATE_W-1:0] rate;
  logic [IDX_W-1:0]  head, tail;
  logic [CNT_W-1:0]  count;
  logic [ORIG_W-1:0] origin;
  logic              origin_valid;

  cmd_t              cmd;
  logic [TAG_W-1:0]  in_tag;
  logic [TS_W-1:0]   in_ts;
  logic [NOW_W-1:0]  now;

  logic [DIFF_W-1:0]    diff;
  logic [PROD_W-1:0]    dvd;
  logic [RATE_W:0]      rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic              res_released, res_dropped;
  entry_t            res_entry;

  logic              s_accept, out_free, div_last, pop;
  logic [RATE_W-1:0] divisor;
  logic [RATE_W:0]   rem_shift;
  logic [IDX_W-1:0]  head_inc, tail_inc;
  logic              q_full, q_empty;

  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign divisor   = (rate == '0) ? RATE_W'(1) : rate;
  assign rem_shift = {rem[RATE_W-1:0], dvd[PROD_W-1]};
  assign div_last  = (div_cnt == DIV_CNT_W'(PROD_W - 1));
  assign head_inc  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign q_full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_empty   = (count == '0);
  assign pop       = !origin_valid || ({{(DIFF_W-PROD_W){1'b0}}, dvd} <= diff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_accept) state_next = ST_EXEC;
      ST_EXEC:   state_next = (cmd == CMD_GET && !q_empty) ? ST_READ : ST_DONE;
      ST_READ:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (div_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ST_IDLE) && !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= DEFAULT_RATE;
    end else if (cfg_wen) begin
      rate <= cfg_wdata;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && cmd == CMD_PUSH && !q_full) begin
      mem[tail] <= '{tag: in_tag, ts: in_ts};
    end
    if (state == ST_READ) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd    <= cmd_t'(s_tuser);
      in_tag <= s_tdata[TAG_W-1:0];
      in_ts  <= s_tdata[TAG_W+TS_W-1:TAG_W];
      now    <= s_tdata[S_TDATA_W-1:TAG_W+TS_W];
    end
    if (state == ST_READ) begin
      diff <= DIFF_W'(now) - {{(DIFF_W-ORIG_W){origin[ORIG_W-1]}}, origin};
    end
    unique case (state)
      ST_MUL: begin
        dvd     <= PROD_W'(rd_data.ts) * PROD_W'(MS_PER_S);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (rem_shift >= {1'b0, divisor}) begin
          rem <= rem_shift - {1'b0, divisor};
          dvd <= {dvd[PROD_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          dvd <= {dvd[PROD_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // queue control and result
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      origin       <= '0;
      origin_valid <= 1'b0;
      res_released <= 1'b0;
      res_dropped  <= 1'b0;
      res_entry    <= '0;
    end else if (state == ST_EXEC) begin
      res_released <= 1'b0;
      res_dropped  <= 1'b0;
      res_entry    <= '0;
      unique case (cmd)
        CMD_PUSH: begin
          if (q_full) begin
            res_dropped <= 1'b1;
          end else begin
            tail  <= tail_inc;
            count <= count + 1'b1;
          end
        end
        CMD_FLUSH: begin
          head         <= '0;
          tail         <= '0;
          count        <= '0;
          origin       <= '0;
          origin_valid <= 1'b0;
        end
        CMD_GET, CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end else if (state == ST_DECIDE) begin
      if (!origin_valid) begin
        origin       <= ORIG_W'(now) - ORIG_W'(dvd);
        origin_valid <= 1'b1;
      end
      if (pop) begin
        head         <= head_inc;
        count        <= count - 1'b1;
        res_released <= 1'b1;
        res_entry    <= rd_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {res_entry.ts, res_entry.tag};
      m_tuser <= {res_dropped, res_released};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty queue with head and tail apart");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> count != '0)
    else $error("release decision on an empty queue");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && cmd == CMD_FLUSH |=> !origin_valid && count == '0)
    else $error("flush left origin or entries behind");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("released and dropped on the same word");

endmodule

### verif/tb_timestamp_paced_release_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_paced_release_queue
// Drives push, get, flush and no-op words into the release queue under
// random sender gaps and receiver stalls, predicts each result word from its
// own model of the fifo, time origin and ms conversion, and checks every
// result in order. Covers rate extremes, full-queue drops, empty gets,
// negative origins and get times right around the release threshold.
// ----------------------------------------------------------------------------
module tb_timestamp_paced_release_queue;
  import tprq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic             released;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  ts;
    logic             dropped;
  } release_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [RATE_W-1:0]    cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;    // pkt_tag, pkt_timestamp, now_ms
  logic [CMD_W-1:0]     s_tuser = '0;    // cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // out_tag, out_timestamp
  logic [M_TUSER_W-1:0] m_tuser;         // released, dropped

  // queue model
  entry_t            fifo_mem [QUEUE_DEPTH];
  int                q_head = 0;
  int                q_tail = 0;
  int                q_count = 0;
  logic [ORIG_W-1:0] origin = '0;
  logic              origin_known = 1'b0;
  logic [RATE_W-1:0] media_rate = DEFAULT_RATE;

  release_t          pending_releases [$];
  int                fail_count = 0;
  int                send_idle_pct = 0;
  int                ready_stall_pct = 0;
  int                stall_hold = 0;
  int                cycle_count = 0;
  logic [TS_W-1:0]   stream_ts;
  logic [NOW_W-1:0]  stream_now;

  timestamp_paced_release_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_timestamp_paced_release_queue failed");
      $finish;
    end
  end

  function automatic logic [63:0] ts_in_ms(input logic [TS_W-1:0] ts);
    logic [63:0] div;
    div = (media_rate == '0) ? 64'd1 : 64'(media_rate);
    return (64'(ts) * 64'd1000) / div;
  endfunction

  function automatic logic [63:0] origin_wide();
    return {{(64-ORIG_W){origin[ORIG_W-1]}}, origin};
  endfunction

  task automatic predict_release(input cmd_t c, input logic [TAG_W-1:0] tag,
                                 input logic [TS_W-1:0] ts, input logic [NOW_W-1:0] now);
    release_t    r;
    logic [63:0] head_ms;
    logic        pop;
    r = '0;
    pop = 1'b0;
    unique case (c)
      CMD_PUSH: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          fifo_mem[q_tail].tag = tag;
          fifo_mem[q_tail].ts  = ts;
          q_tail  = (q_tail + 1) % QUEUE_DEPTH;
          q_count = q_count + 1;
        end
      end
      CMD_GET: begin
        if (q_count != 0) begin
          head_ms = ts_in_ms(fifo_mem[q_head].ts);
          if (!origin_known) begin
            origin       = ORIG_W'(64'(now) - head_ms);
            origin_known = 1'b1;
            pop          = 1'b1;
          end else begin
            pop = (head_ms <= (64'(now) - origin_wide()));
          end
        end
      end
      CMD_FLUSH: begin
        q_head       = 0;
        q_tail       = 0;
        q_count      = 0;
        origin       = '0;
        origin_known = 1'b0;
      end
      default: begin
      end
    endcase
    if (pop) begin
      r.released = 1'b1;
      r.tag      = fifo_mem[q_head].tag;
      r.ts       = fifo_mem[q_head].ts;
      q_head     = (q_head + 1) % QUEUE_DEPTH;
      q_count    = q_count - 1;
    end
    pending_releases.push_back(r);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    release_t got;
    release_t exp;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.released = m_tuser[0];
        got.dropped  = m_tuser[1];
        got.tag      = m_tdata[TAG_W-1:0];
        got.ts       = m_tdata[TAG_W +: TS_W];
        if (pending_releases.size() == 0) begin
          $display("%0t: unexpected word released=%0b tag=%h ts=%h dropped=%0b", $time,
                   got.released, got.tag, got.ts, got.dropped);
          fail_count++;
        end else begin
          exp = pending_releases.pop_front();
          if (got.released !== exp.released) begin
            $display("%0t: released exp %0b got %0b", $time, exp.released, got.released);
            fail_count++;
          end
          if (got.tag !== exp.tag) begin
            $display("%0t: out_tag exp %h got %h", $time, exp.tag, got.tag);
            fail_count++;
          end
          if (got.ts !== exp.ts) begin
            $display("%0t: out_timestamp exp %h got %h", $time, exp.ts, got.ts);
            fail_count++;
          end
          if (got.dropped !== exp.dropped) begin
            $display("%0t: dropped exp %0b got %0b", $time, exp.dropped, got.dropped);
            fail_count++;
          end
        end
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  task automatic send_word(input cmd_t c, input logic [TAG_W-1:0] tag,
                           input logic [TS_W-1:0] ts, input logic [NOW_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {now, ts, tag};
    do @(posedge clk); while (!s_tready);
    predict_release(c, tag, ts, now);
  endtask

  task automatic wait_for_releases();
    s_tvalid <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    cfg_wen   <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    media_rate  = rate;
  endtask

  function automatic logic [NOW_W-1:0] random_now();
    return NOW_W'({$urandom, $urandom});
  endfunction

  // mostly ordered pushes with rising timestamps and gets right at the threshold
  task automatic run_stream(input int n);
    int          r;
    int          delta;
    logic [63:0] thr;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_word(cmd_t'($urandom_range(3)), TAG_W'($urandom), $urandom, random_now());
      end else if (r < 8) begin
        send_word(CMD_FLUSH, TAG_W'($urandom), $urandom, random_now());
      end else if (r < 52 && !(q_count >= QUEUE_DEPTH && $urandom_range(3) != 0)) begin
        if ($urandom_range(19) == 0)
          stream_ts = $urandom;
        else
          stream_ts = stream_ts + $urandom_range(media_rate / 10 + 2);
        send_word(CMD_PUSH, TAG_W'($urandom), stream_ts, random_now());
      end else begin
        if (q_count == 0 || !origin_known) begin
          if ($urandom_range(3) == 0)
            stream_now = random_now();
          else
            stream_now = stream_now + $urandom_range(50);
          send_word(CMD_GET, TAG_W'($urandom), $urandom, stream_now);
        end else begin
          thr = origin_wide() + ts_in_ms(fifo_mem[q_head].ts);
          if ($urandom_range(9) == 0) begin
            thr = thr + 64'($urandom_range(100000)) - 64'd50000;
          end else begin
            delta = $urandom_range(6);
            thr   = thr + 64'(delta) - 64'd3;
          end
          send_word(CMD_GET, TAG_W'($urandom), $urandom, NOW_W'(thr));
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    send_word(CMD_GET, '0, '0, '1);
    send_word(CMD_NOP, '1, '1, '1);
    send_word(CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, '0);
    send_word(CMD_PUSH, 16'h0000, 32'h0000_0000, '1);
    send_word(CMD_GET, '0, '0, '0);                   // negative origin
    send_word(CMD_GET, '1, '1, '1);
    send_word(CMD_GET, '0, '0, 48'd100);
    send_word(CMD_FLUSH, '1, '1, '1);
    send_word(CMD_PUSH, 16'hA5A5, 32'd16000, '0);
    send_word(CMD_PUSH, 16'h5A5A, 32'd24000, '0);
    send_word(CMD_GET, '0, '0, 48'd5000);
    send_word(CMD_GET, '0, '0, 48'd5999);             // one ms early
    send_word(CMD_GET, '0, '0, 48'd6000);             // exactly on time
    send_word(CMD_PUSH, 16'h0F0F, 32'd0, '0);
    send_word(CMD_GET, '0, '0, 48'd2999);             // now before origin
    send_word(CMD_GET, '0, '0, 48'd7000);
    wait_for_releases();
  endtask

  task automatic test_rate_extremes();
    logic [RATE_W-1:0] rates [4];
    rates = '{20'd0, 20'd1, 20'hFFFFF, 20'd1000000};
    foreach (rates[k]) begin
      write_rate(rates[k]);
      send_word(CMD_FLUSH, '0, '0, '0);
      send_word(CMD_PUSH, TAG_W'($urandom), 32'hFFFF_FFFF, '0);
      run_stream(40);
      wait_for_releases();
    end
  endtask

  task automatic test_backpressure();
    write_rate(20'd8000);
    send_word(CMD_FLUSH, '0, '0, '0);
    stall_hold = 400;
    for (int i = 0; i < 20; i++)
      send_word(CMD_PUSH, TAG_W'($urandom), $urandom, random_now());
    wait_for_releases();
    stall_hold = 300;
    run_stream(40);
    wait_for_releases();
  endtask

  task automatic test_random_phases();
    int idle_pct [4];
    int stall_pct [4];
    idle_pct  = '{0, 53, 0, 23};
    stall_pct = '{0, 0, 53, 23};
    foreach (idle_pct[p]) begin
      write_rate(RATE_W'($urandom_range(1000000, 1)));
      send_idle_pct   = idle_pct[p];
      ready_stall_pct = stall_pct[p];
      run_stream(400);
      wait_for_releases();
    end
  endtask

  initial begin
    stream_ts  = $urandom;
    stream_now = random_now();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_rate_extremes();
    test_backpressure();
    test_random_phases();
    wait_for_releases();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_releases.size() == 0) begin
      $display("tb_timestamp_paced_release_queue passed");
    end else begin
      $display("tb_timestamp_paced_release_queue failed");
    end
    $finish;
  end

endmodule

### timestamp_paced_release_queue.f
design/tprq_pkg.sv
design/timestamp_paced_release_queue.sv
verif/tb_timestamp_paced_release_queue.sv
